// ----- sv/sorted_priority_queue_assert.svh -----
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Clocked check shorthands used by the queue RTL; they expect clk and rst_n
// in scope.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define SPQ_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("spq: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define SPQ_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("spq: next-cycle check failed");

`endif

// ----- sv/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, operation and status codes, and types shared by the cell and top.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int PAY_W = 32;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // one cell's contents
  typedef struct packed {
    logic                     valid;
    logic signed [KEY_W-1:0]  key;
    logic signed [PAY_W-1:0]  pay;
  } cell_data_t;

  // broadcast command to every cell
  typedef struct packed {
    logic ins;  // insert, queue not full
    logic rem;  // remove front, queue not empty
  } cell_ctrl_t;

endpackage

// ----- sv/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded min-queue on a signed key with payload, held sorted in a chain of
// cells; equal keys leave in arrival order.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Handshake
//  -------   -------------------------------------   -------------------------
//  input     in_mode, in_key_in, in_payload_in       start high, busy low
//  result    out_status, out_removed_*, out_front_*, out_strobe, one cycle,
//            out_entry_count, out_is_empty            cannot be held off
//
//  All cells compare the broadcast key in parallel and shift or load in the
//  same edge, so a new transaction is accepted every cycle while busy is low.
//  Its result shows on the next cycle with out_strobe.
//  busy is high during reset and in the first cycle after reset.
//  Reset empties the queue by clearing the cell valid bits.
//  The receiver cannot stall; results are not buffered.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_mode,
  input  logic signed [spq_pkg::KEY_W-1:0]  in_key_in,
  input  logic signed [spq_pkg::PAY_W-1:0]  in_payload_in,
  output logic                              out_strobe,
  output logic [1:0]                        out_status,
  output logic signed [spq_pkg::KEY_W-1:0]  out_removed_key,
  output logic signed [spq_pkg::PAY_W-1:0]  out_removed_payload,
  output logic signed [spq_pkg::KEY_W-1:0]  out_front_key,
  output logic signed [spq_pkg::PAY_W-1:0]  out_front_payload,
  output logic [4:0]                        out_entry_count,
  output logic                              out_is_empty
);

  localparam int D = spq_pkg::DEPTH;

  // ---- control registers ---------------------------------------------------
  logic                       busy_r;
  logic                       strobe_r, strobe_nxt;
  logic [spq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [1:0]                 status_r, status_nxt;
  logic signed [spq_pkg::KEY_W-1:0] rem_key_r, rem_key_nxt;
  logic signed [spq_pkg::PAY_W-1:0] rem_pay_r, rem_pay_nxt;

  logic                 accept;
  logic                 is_full, is_empty_now;
  spq_pkg::cell_ctrl_t  ctrl;

  // ---- cell chain ----------------------------------------------------------
  spq_pkg::cell_data_t  chain_d  [D];
  logic [D-1:0]         gt_vec;
  logic [D-1:0]         valid_vec;
  logic [D-1:0]         order_ok;

  assign accept       = start && !busy_r;
  assign is_full      = (count_r == spq_pkg::CNT_W'(D));
  assign is_empty_now = (count_r == '0);

  // Command broadcast to every cell in the accepting cycle
  always_comb begin
    ctrl.ins = accept && (in_mode == spq_pkg::MODE_INSERT) && !is_full;
    ctrl.rem = accept && (in_mode == spq_pkg::MODE_REMOVE) && !is_empty_now;
  end

  genvar gi;
  generate
    for (gi = 0; gi < D; gi++) begin : g_cell
      spq_pkg::cell_data_t left_d, right_d;
      logic                left_gt;

      if (gi == 0) begin : g_head
        assign left_d  = '0;
        assign left_gt = 1'b0;
      end else begin : g_body
        assign left_d  = chain_d[gi-1];
        assign left_gt = gt_vec[gi-1];
      end

      if (gi == D - 1) begin : g_tail
        assign right_d = '0;
      end else begin : g_mid
        assign right_d = chain_d[gi+1];
      end

      spq_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .key_in  (in_key_in),
        .pay_in  (in_payload_in),
        .left_d  (left_d),
        .left_gt (left_gt),
        .right_d (right_d),
        .cell_d  (chain_d[gi]),
        .cell_gt (gt_vec[gi])
      );

      assign valid_vec[gi] = chain_d[gi].valid;

      // neighbor ordering, only checked by assertions
      if (gi == D - 1) begin : g_ord_tail
        assign order_ok[gi] = 1'b1;
      end else begin : g_ord_mid
        assign order_ok[gi] = !chain_d[gi+1].valid ||
                              (chain_d[gi].key <= chain_d[gi+1].key);
      end
    end
  endgenerate

  // ---- transaction bookkeeping ---------------------------------------------
  always_comb begin
    strobe_nxt  = accept;
    count_nxt   = count_r;
    status_nxt  = status_r;
    rem_key_nxt = rem_key_r;
    rem_pay_nxt = rem_pay_r;
    if (accept) begin
      status_nxt  = spq_pkg::ST_OK;
      rem_key_nxt = '0;
      rem_pay_nxt = '0;
      unique case (in_mode)
        spq_pkg::MODE_INSERT: begin
          if (is_full) begin
            status_nxt = spq_pkg::ST_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        spq_pkg::MODE_REMOVE: begin
          if (is_empty_now) begin
            status_nxt = spq_pkg::ST_EMPTY;
          end else begin
            rem_key_nxt = chain_d[0].key;
            rem_pay_nxt = chain_d[0].pay;
            count_nxt   = count_r - 1'b1;
          end
        end
        default: begin
          // peek, and the unused code behaves as a peek
          if (is_empty_now) begin
            status_nxt = spq_pkg::ST_EMPTY;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      strobe_r <= 1'b0;
      count_r  <= '0;
    end else begin
      busy_r   <= 1'b0;
      strobe_r <= strobe_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    rem_key_r <= rem_key_nxt;
    rem_pay_r <= rem_pay_nxt;
  end

  // ---- result ports --------------------------------------------------------
  // Front fields come straight from the head cell, which already holds the
  // post-transaction state in the strobe cycle.
  logic [spq_pkg::CNT_W+4:0] count_ext;
  assign count_ext = {5'b0, count_r};

  assign busy                = busy_r;
  assign out_strobe          = strobe_r;
  assign out_status          = status_r;
  assign out_removed_key     = rem_key_r;
  assign out_removed_payload = rem_pay_r;
  assign out_front_key       = chain_d[0].valid ? chain_d[0].key : '0;
  assign out_front_payload   = chain_d[0].valid ? chain_d[0].pay : '0;
  assign out_entry_count     = count_ext[4:0];
  assign out_is_empty        = is_empty_now;

  // ---- assertions ----------------------------------------------------------
`include "sorted_priority_queue_assert.svh"

  `SPQ_ASSERT_SAME(a_valid_prefix, 1'b1, (valid_vec & (valid_vec + 1'b1)) == '0)
  `SPQ_ASSERT_SAME(a_count_match, 1'b1, $countones(valid_vec) == 32'(count_r))
  `SPQ_ASSERT_SAME(a_sorted, 1'b1, &order_ok)
  `SPQ_ASSERT_NEXT(a_ins_grows, ctrl.ins, count_r == $past(count_r) + 1'b1)
  `SPQ_ASSERT_NEXT(a_rem_front, ctrl.rem, out_removed_key == $past(chain_d[0].key))

endmodule

// ----- sv/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: compares the broadcast key, then keeps,
// takes the new entry, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spq_pkg::cell_ctrl_t               ctrl,
  input  logic signed [spq_pkg::KEY_W-1:0]  key_in,
  input  logic signed [spq_pkg::PAY_W-1:0]  pay_in,
  input  spq_pkg::cell_data_t               left_d,
  input  logic                              left_gt,
  input  spq_pkg::cell_data_t               right_d,
  output spq_pkg::cell_data_t               cell_d,
  output logic                              cell_gt
);

  logic                             valid_r, valid_nxt;
  logic signed [spq_pkg::KEY_W-1:0] key_r, key_nxt;
  logic signed [spq_pkg::PAY_W-1:0] pay_r, pay_nxt;

  // new key goes at or before this slot (strict less keeps FIFO on ties)
  assign cell_gt = !valid_r || (key_in < key_r);

  // insert and remove never come together; with neither the slot holds
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    pay_nxt   = pay_r;
    if (ctrl.ins && cell_gt) begin
      if (left_gt) begin
        valid_nxt = left_d.valid;
        key_nxt   = left_d.key;
        pay_nxt   = left_d.pay;
      end else begin
        valid_nxt = 1'b1;
        key_nxt   = key_in;
        pay_nxt   = pay_in;
      end
    end else if (ctrl.rem) begin
      valid_nxt = right_d.valid;
      key_nxt   = right_d.key;
      pay_nxt   = right_d.pay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign cell_d = '{valid: valid_r, key: key_r, pay: pay_r};

endmodule

// ----- tb/sorted_priority_queue_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert, remove and peek transactions through the start/busy port,
// predicts every result with a behavioral sorted list, and compares each
// strobed result field by field in arrival order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
  import spq_pkg::*;

  // mode 3 is not a defined operation; the queue treats it as a peek
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int MAX_REPORTED = 10;

  // one transaction as the driver sees it: payload plus pacing
  typedef struct {
    logic [1:0]              mode;
    logic signed [KEY_W-1:0] key;
    logic signed [PAY_W-1:0] pay;
    int                      gap;    // idle cycles before presenting it
    bit                      drain;  // hold off until no result is pending
  } queue_op_t;

  // what the queue reports for one transaction
  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] rem_key;
    logic signed [PAY_W-1:0] rem_pay;
    logic signed [KEY_W-1:0] front_key;
    logic signed [PAY_W-1:0] front_pay;
    logic [4:0]              count;
    logic                    empty;
  } queue_report_t;

  // clock and DUT ports; every input is known from time zero
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              in_mode = MODE_PEEK;
  logic signed [KEY_W-1:0] in_key_in = '0;
  logic signed [PAY_W-1:0] in_payload_in = '0;
  logic                    out_strobe;
  logic [1:0]              out_status;
  logic signed [KEY_W-1:0] out_removed_key;
  logic signed [PAY_W-1:0] out_removed_payload;
  logic signed [KEY_W-1:0] out_front_key;
  logic signed [PAY_W-1:0] out_front_payload;
  logic [4:0]              out_entry_count;
  logic                    out_is_empty;

  // shadow copy of the queue contents, ascending by key
  logic signed [KEY_W-1:0] shadow_keys [DEPTH];
  logic signed [PAY_W-1:0] shadow_pays [DEPTH];
  int                      shadow_count = 0;

  queue_op_t     pending_ops [$];     // stimulus not yet driven
  queue_report_t predicted_reports [$];
  queue_op_t     cur_op;
  bit            have_op = 1'b0;
  int            gap_left = 0;
  logic          fire = 1'b0;         // a transaction was taken at the last edge
  queue_report_t seen;
  queue_report_t want;
  int            mismatches = 0;

  sorted_priority_queue dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_key_in           (in_key_in),
    .in_payload_in       (in_payload_in),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_removed_key     (out_removed_key),
    .out_removed_payload (out_removed_payload),
    .out_front_key       (out_front_key),
    .out_front_payload   (out_front_payload),
    .out_entry_count     (out_entry_count),
    .out_is_empty        (out_is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the shadow list and return the expected report.
  // New entries go behind every entry with a key not greater than theirs,
  // which keeps equal keys in arrival order.
  function automatic queue_report_t apply_queue_op(logic [1:0] mode,
                                                   logic signed [KEY_W-1:0] key,
                                                   logic signed [PAY_W-1:0] pay);
    queue_report_t r;
    int pos;
    int i;
    r = '0;
    r.status = ST_OK;
    if (mode == MODE_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;          // dropped, list untouched
      end else begin
        pos = 0;
        while (pos < shadow_count && !(key < shadow_keys[pos])) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
          shadow_pays[i] = shadow_pays[i-1];
        end
        shadow_keys[pos] = key;
        shadow_pays[pos] = pay;
        shadow_count++;
      end
    end else if (mode == MODE_REMOVE) begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.rem_key = shadow_keys[0];
        r.rem_pay = shadow_pays[0];
        for (i = 1; i < shadow_count; i++) begin
          shadow_keys[i-1] = shadow_keys[i];
          shadow_pays[i-1] = shadow_pays[i];
        end
        shadow_count--;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;           // peek, or the unused mode
    end
    if (shadow_count != 0) begin
      r.front_key = shadow_keys[0];
      r.front_pay = shadow_pays[0];
    end
    r.count = 5'(shadow_count);
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] exp_val, logic [31:0] act_val);
    mismatches++;
    if (mismatches <= MAX_REPORTED)
      $display("[%0t] %s: expected %h, got %h", $realtime, field, exp_val, act_val);
  endtask

  // Monitor: check the strobed result against the oldest prediction, then
  // predict for a transaction taken at this edge. Its result shows in the next
  // cycle, so the check always refers to an earlier transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        seen = '{out_status, out_removed_key, out_removed_payload, out_front_key,
                 out_front_payload, out_entry_count, out_is_empty};
        if (predicted_reports.size() == 0) begin
          flag_mismatch("unexpected result, status", 'x, 32'(seen.status));
        end else begin
          want = predicted_reports[0];
          predicted_reports.delete(0);
          if (seen.status !== want.status)
            flag_mismatch("status", 32'(want.status), 32'(seen.status));
          if (seen.rem_key !== want.rem_key)
            flag_mismatch("removed_key", want.rem_key, seen.rem_key);
          if (seen.rem_pay !== want.rem_pay)
            flag_mismatch("removed_payload", want.rem_pay, seen.rem_pay);
          if (seen.front_key !== want.front_key)
            flag_mismatch("front_key", want.front_key, seen.front_key);
          if (seen.front_pay !== want.front_pay)
            flag_mismatch("front_payload", want.front_pay, seen.front_pay);
          if (seen.count !== want.count)
            flag_mismatch("entry_count", 32'(want.count), 32'(seen.count));
          if (seen.empty !== want.empty)
            flag_mismatch("is_empty", 32'(want.empty), 32'(seen.empty));
        end
      end
      if (start && !busy)
        predicted_reports.push_back(apply_queue_op(in_mode, in_key_in, in_payload_in));
    end
    fire <= rst_n && start && !busy;
  end

  // Driver: updates on the falling edge. Retires the current transaction once
  // it was taken, waits out its gap (and a full drain when asked), then holds
  // start high until busy lets it through. Idle cycles carry junk data.
  always @(negedge clk) begin
    if (fire) have_op = 1'b0;
    if (rst_n && !have_op && pending_ops.size() != 0) begin
      cur_op = pending_ops[0];
      pending_ops.delete(0);
      have_op = 1'b1;
      gap_left = cur_op.gap;
    end
    if (have_op && gap_left == 0 && !(cur_op.drain && predicted_reports.size() != 0))
    begin
      start         <= 1'b1;
      in_mode       <= cur_op.mode;
      in_key_in     <= cur_op.key;
      in_payload_in <= cur_op.pay;
    end else begin
      if (have_op && gap_left > 0) gap_left--;
      start         <= 1'b0;
      in_mode       <= 2'($urandom);
      in_key_in     <= $urandom;
      in_payload_in <= $urandom;
    end
  end

  task automatic add_op(logic [1:0] mode, logic [31:0] key, logic [31:0] pay,
                        int gap, bit drain);
    queue_op_t op;
    op.mode = mode;
    op.key = key;
    op.pay = pay;
    op.gap = gap;
    op.drain = drain;
    pending_ops.push_back(op);
  endtask

  // geometric run of idle cycles; pct is the idle share in percent
  function automatic int idle_gap(int pct);
    int g;
    g = 0;
    while (g < 12 && $urandom_range(0, 99) < pct) g++;
    return g;
  endfunction

  // keys lean toward ties and the ends of the signed range
  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    case ($urandom_range(0, 9))
      0:       k = 32'h7fff_ffff - $urandom_range(0, 2);
      1:       k = 32'h8000_0000 + $urandom_range(0, 2);
      2, 3, 4: k = 32'(($urandom_range(0, 7) - 4) * 65536);
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] pick_pay();
    logic [31:0] p;
    case ($urandom_range(0, 15))
      0:       p = 32'h8000_0000;
      1:       p = 32'h7fff_ffff;
      2:       p = 32'hffff_ffff;
      3:       p = 32'h0;
      default: p = $urandom;
    endcase
    return p;
  endfunction

  // Random phase: bursts that lean toward filling, emptying or a mix, so the
  // count swings between empty and full over and over.
  task automatic add_random_phase(int n_ops, int idle_pct);
    int left;
    int burst;
    int bias;
    int roll;
    logic [1:0] mode;
    left = n_ops;
    while (left > 0) begin
      burst = $urandom_range(10, 40);
      bias = $urandom_range(0, 2);
      while (burst > 0 && left > 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 3)
          mode = MODE_UNUSED;
        else if (roll < 12)
          mode = MODE_PEEK;
        else if (roll < (bias == 0 ? 80 : bias == 1 ? 25 : 55))
          mode = MODE_INSERT;
        else
          mode = MODE_REMOVE;
        // first transaction of a phase, and now and then later, waits for
        // the queue's outstanding result before it goes out
        add_op(mode, pick_key(), pick_pay(), idle_gap(idle_pct),
               left == n_ops || $urandom_range(0, 99) == 0);
        burst--;
        left--;
      end
    end
  endtask

  initial begin
    // directed: empty-queue errors and the unused mode first
    add_op(MODE_PEEK,   32'h0, 32'h0, 0, 1'b0);
    add_op(MODE_REMOVE, 32'h0, 32'h0, 0, 1'b0);
    add_op(MODE_UNUSED, 32'h0, 32'h0, 0, 1'b0);
    // sixteen inserts fill the queue: range ends, sign boundary, ties
    add_op(MODE_INSERT, 32'h7fff_ffff, 32'h8000_0000, 0, 1'b0);
    add_op(MODE_INSERT, 32'h8000_0000, 32'h7fff_ffff, 0, 1'b0);
    add_op(MODE_INSERT, 32'h0000_0000, 32'hffff_ffff, 0, 1'b0);
    add_op(MODE_INSERT, 32'hffff_ffff, 32'h0000_0000, 0, 1'b0);
    add_op(MODE_INSERT, 32'h0000_0000, 32'h0000_0001, 0, 1'b0);
    add_op(MODE_INSERT, 32'h8000_0000, 32'h0000_0002, 0, 1'b0);
    add_op(MODE_INSERT, 32'h0000_0001, 32'h5555_5555, 0, 1'b0);
    add_op(MODE_INSERT, 32'hffff_0000, 32'haaaa_aaaa, 0, 1'b0);
    add_op(MODE_INSERT, 32'h7fff_ffff, 32'h0000_0003, 0, 1'b0);
    add_op(MODE_INSERT, 32'h0001_0000, 32'h1234_5678, 0, 1'b0);
    add_op(MODE_INSERT, 32'h0000_0000, 32'h0000_0004, 0, 1'b0);
    add_op(MODE_INSERT, 32'h8000_0001, 32'hdead_beef, 0, 1'b0);
    add_op(MODE_INSERT, 32'h7fff_fffe, 32'hcafe_f00d, 0, 1'b0);
    add_op(MODE_INSERT, 32'h0002_8000, 32'h0f0f_0f0f, 0, 1'b0);
    add_op(MODE_INSERT, 32'hfffe_8000, 32'hf0f0_f0f0, 0, 1'b0);
    add_op(MODE_INSERT, 32'h0000_0000, 32'h0000_0005, 0, 1'b0);
    // full: insert is refused, peeks see the smallest key
    add_op(MODE_INSERT, 32'h8000_0000, 32'h7777_7777, 0, 1'b0);
    add_op(MODE_PEEK,   32'h0, 32'h0, 0, 1'b0);
    add_op(MODE_UNUSED, 32'h0, 32'h0, 0, 1'b0);
    // two most-negative keys leave in arrival order, then room again
    add_op(MODE_REMOVE, 32'h0, 32'h0, 0, 1'b0);
    add_op(MODE_REMOVE, 32'h0, 32'h0, 0, 1'b0);
    add_op(MODE_INSERT, 32'h8000_0000, 32'h0000_0006, 0, 1'b0);

    // random phases: back to back, sender idle about half the time, then
    // about a fifth of the time
    add_random_phase(475, 0);
    add_random_phase(475, 49);
    add_random_phase(475, 20);

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_ops.size() != 0 || have_op || predicted_reports.size() != 0)
      @(posedge clk);
    // the extra edges catch stray strobes
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sorted_priority_queue.f -----
+incdir+sv
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
tb/sorted_priority_queue_test.sv
